FILE: rtl/ctd_pkg.sv
// shared constants and types for the capacitive touch detector
package ctd_pkg;

   localparam int COUNT_BITS      = 16;
   localparam int MAX_CAL_SAMPLES = 256;

   localparam int CNT_W   = 16;
   localparam int CAL_W   = 9;
   localparam int SUM_W   = 24;
   localparam int BLEND_W = 9;
   localparam int CSR_W   = 16;
   localparam int IDX_W   = 2;
   localparam int STEP_W  = 5;

   localparam logic [CNT_W-1:0]   RAW_MASK   = CNT_W'((32'd1 << COUNT_BITS) - 32'd1);
   localparam logic [CAL_W-1:0]   CAL_MAX    = CAL_W'(MAX_CAL_SAMPLES);
   localparam logic [BLEND_W-1:0] BLEND_ONE  = BLEND_W'(256);
   localparam logic [STEP_W-1:0]  DIV_STEPS  = STEP_W'(SUM_W);
   localparam logic [STEP_W-1:0]  MUL_STEPS  = STEP_W'(BLEND_W);

   typedef enum logic [IDX_W-1:0] {
      REG_CAL_SAMPLES    = 2'd0,
      REG_BLEND_Q8       = 2'd1,
      REG_PRESS_OFFSET   = 2'd2,
      REG_RELEASE_OFFSET = 2'd3
   } ctd_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_POST,
      ST_OUT
   } ctd_state_type;

endpackage

FILE: rtl/ctd_req_if.sv
// input channel interface: one raw count per transfer
interface ctd_req_if;
   import ctd_pkg::*;

   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] raw_count;

   modport source (output valid, output raw_count, input ready);
   modport sink (input valid, input raw_count, output ready);
endinterface

// result channel interface: touch state and baseline per transfer
interface ctd_rsp_if;
   import ctd_pkg::*;

   logic             valid;
   logic             ready;
   logic             is_touched;
   logic [CNT_W-1:0] echo_raw;
   logic [CNT_W-1:0] current_baseline;
   logic             calibrating;

   modport source (output valid, output is_touched, output echo_raw,
                   output current_baseline, output calibrating, input ready);
   modport sink (input valid, input is_touched, input echo_raw,
                 input current_baseline, input calibrating, output ready);
endinterface

FILE: rtl/capacitive_touch_detector_top.sv
// Touch detector: start-up mean baseline, blended baseline tracking and
// press/release hysteresis on one raw count per transfer. One sample is in
// work at a time. A calibration sample goes straight to the result, the sample
// that ends calibration first runs a bit-serial restoring divider (one
// quotient bit per cycle over 24 bits), a sample that updates the baseline runs
// a bit-serial blend multiply over the 9 weight bits and then the press compare,
// and a held touch goes straight to the result. The result sits in an
// output register; a new sample is taken once the previous result is
// registered, even while that result still waits for its transfer.
module capacitive_touch_detector_top
   import ctd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   ctd_req_if.sink          req_if,
   ctd_rsp_if.source        rsp_if,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   ctd_state_type       state_ff, state_in;

   logic [CAL_W-1:0]    cal_samples_ff;
   logic [BLEND_W-1:0]  blend_ff;
   logic [CNT_W-1:0]    press_ff;
   logic [CNT_W-1:0]    release_ff;

   logic [CNT_W-1:0]    base_ff, base_in;
   logic                touch_ff, touch_in;
   logic [SUM_W-1:0]    cal_sum_ff, cal_sum_in;
   logic [CAL_W-1:0]    cal_count_ff, cal_count_in;
   logic                cal_active_ff, cal_active_in;
   logic                check_press_ff, check_press_in;

   logic [CNT_W-1:0]    raw_ff, raw_in;
   logic [SUM_W-1:0]    work_ff, work_in;
   logic [CAL_W-1:0]    rem_ff, rem_in;
   logic [CAL_W-1:0]    divisor_ff, divisor_in;
   logic [BLEND_W-1:0]  wgt_ff, wgt_in;
   logic [BLEND_W-1:0]  wcomp_ff, wcomp_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_touch_ff, rsp_touch_in;
   logic [CNT_W-1:0]    rsp_raw_ff, rsp_raw_in;
   logic [CNT_W-1:0]    rsp_base_ff, rsp_base_in;
   logic                rsp_cal_ff, rsp_cal_in;

   logic                accept;
   logic                slot_free;
   logic                step_last;
   logic [CNT_W-1:0]    raw_used;
   logic [CAL_W-1:0]    need;
   logic [SUM_W-1:0]    sum_next;
   logic [CAL_W-1:0]    count_next;
   logic                cal_done;
   logic [BLEND_W-1:0]  w_sat;
   logic                release_hold;
   logic                press_hit;
   logic [CAL_W-1:0]    div_trial;
   logic                div_bit;
   logic [SUM_W-1:0]    div_work;
   logic [SUM_W-1:0]    mul_next;

   // shared conditions
   assign accept    = req_if.valid && (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign step_last = (step_ff == '0);
   assign raw_used  = req_if.raw_count & RAW_MASK;

   always_comb begin
      if (cal_samples_ff == '0) begin
         need = CAL_W'(1);
      end else if (cal_samples_ff > CAL_MAX) begin
         need = CAL_MAX;
      end else begin
         need = cal_samples_ff;
      end
   end

   assign sum_next   = cal_sum_ff + SUM_W'(raw_used);
   assign count_next = cal_count_ff + CAL_W'(1);
   assign cal_done   = (count_next >= need);
   assign w_sat      = (blend_ff > BLEND_ONE) ? BLEND_ONE : blend_ff;

   assign release_hold = {1'b0, raw_used} > ({1'b0, base_ff} + {1'b0, release_ff});
   assign press_hit    = {1'b0, raw_ff} > ({1'b0, base_ff} + {1'b0, press_ff});

   // one restoring division step
   assign div_trial = {rem_ff[CAL_W-2:0], work_ff[SUM_W-1]};
   assign div_bit   = (div_trial >= divisor_ff);
   assign div_work  = {work_ff[SUM_W-2:0], div_bit};

   // one msb-first blend step: acc*2 + base*wcomp_bit + raw*w_bit
   assign mul_next = {work_ff[SUM_W-2:0], 1'b0}
                   + (wcomp_ff[BLEND_W-1] ? SUM_W'(base_ff) : '0)
                   + (wgt_ff[BLEND_W-1] ? SUM_W'(raw_ff) : '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (cal_active_ff) begin
                  state_in = cal_done ? ST_DIV : ST_OUT;
               end else if (touch_ff && release_hold) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_DIV: begin
            if (step_last) begin
               state_in = ST_OUT;
            end
         end
         ST_MUL: begin
            if (step_last) begin
               state_in = ST_POST;
            end
         end
         ST_POST: state_in = ST_OUT;
         ST_OUT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      base_in        = base_ff;
      touch_in       = touch_ff;
      cal_sum_in     = cal_sum_ff;
      cal_count_in   = cal_count_ff;
      cal_active_in  = cal_active_ff;
      check_press_in = check_press_ff;
      raw_in         = raw_ff;
      work_in        = work_ff;
      rem_in         = rem_ff;
      divisor_in     = divisor_ff;
      wgt_in         = wgt_ff;
      wcomp_in       = wcomp_ff;
      step_in        = step_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_touch_in   = rsp_touch_ff;
      rsp_raw_in     = rsp_raw_ff;
      rsp_base_in    = rsp_base_ff;
      rsp_cal_in     = rsp_cal_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               raw_in = raw_used;
               if (cal_active_ff) begin
                  cal_sum_in   = sum_next;
                  cal_count_in = count_next;
                  work_in      = sum_next;
                  rem_in       = '0;
                  divisor_in   = count_next;
                  step_in      = DIV_STEPS - STEP_W'(1);
               end else begin
                  work_in  = '0;
                  wgt_in   = w_sat;
                  wcomp_in = BLEND_ONE - w_sat;
                  step_in  = MUL_STEPS - STEP_W'(1);
                  if (touch_ff) begin
                     check_press_in = 1'b0;
                     if (!release_hold) begin
                        touch_in = 1'b0;
                     end
                  end else begin
                     check_press_in = 1'b1;
                  end
               end
            end
         end
         ST_DIV: begin
            work_in = div_work;
            rem_in  = div_bit ? (div_trial - divisor_ff) : div_trial;
            step_in = step_ff - STEP_W'(1);
            if (step_last) begin
               base_in       = div_work[CNT_W-1:0] & RAW_MASK;
               touch_in      = 1'b0;
               cal_active_in = 1'b0;
            end
         end
         ST_MUL: begin
            work_in  = mul_next;
            wgt_in   = {wgt_ff[BLEND_W-2:0], 1'b0};
            wcomp_in = {wcomp_ff[BLEND_W-2:0], 1'b0};
            step_in  = step_ff - STEP_W'(1);
            if (step_last) begin
               base_in = mul_next[SUM_W-1:SUM_W-CNT_W] & RAW_MASK;
            end
         end
         ST_POST: begin
            if (check_press_ff) begin
               touch_in = press_hit;
            end
         end
         ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_touch_in = touch_ff;
               rsp_raw_in   = raw_ff;
               rsp_base_in  = base_ff;
               rsp_cal_in   = cal_active_ff;
            end
         end
         default: ;
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_samples_ff <= CAL_W'(32);
         blend_ff       <= BLEND_W'(26);
         press_ff       <= CNT_W'(200);
         release_ff     <= CNT_W'(100);
      end else if (csr_we) begin
         case (ctd_reg_type'(csr_index))
            REG_CAL_SAMPLES:    cal_samples_ff <= csr_wdata[CAL_W-1:0];
            REG_BLEND_Q8:       blend_ff       <= csr_wdata[BLEND_W-1:0];
            REG_PRESS_OFFSET:   press_ff       <= csr_wdata[CNT_W-1:0];
            REG_RELEASE_OFFSET: release_ff     <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         base_ff       <= '0;
         touch_ff      <= 1'b0;
         cal_sum_ff    <= '0;
         cal_count_ff  <= '0;
         cal_active_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         base_ff       <= base_in;
         touch_ff      <= touch_in;
         cal_sum_ff    <= cal_sum_in;
         cal_count_ff  <= cal_count_in;
         cal_active_ff <= cal_active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      check_press_ff <= check_press_in;
      raw_ff         <= raw_in;
      work_ff        <= work_in;
      rem_ff         <= rem_in;
      divisor_ff     <= divisor_in;
      wgt_ff         <= wgt_in;
      wcomp_ff       <= wcomp_in;
      step_ff        <= step_in;
      rsp_touch_ff   <= rsp_touch_in;
      rsp_raw_ff     <= rsp_raw_in;
      rsp_base_ff    <= rsp_base_in;
      rsp_cal_ff     <= rsp_cal_in;
   end

   assign req_if.ready            = (state_ff == ST_IDLE);
   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.is_touched       = rsp_touch_ff;
   assign rsp_if.echo_raw         = rsp_raw_ff;
   assign rsp_if.current_baseline = rsp_base_ff;
   assign rsp_if.calibrating      = rsp_cal_ff;

endmodule

FILE: rtl/ctd_checker.sv
// port-level checks for the touch detector and their binding
module ctd_checker
   import ctd_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_is_touched,
   input logic [CNT_W-1:0] rsp_echo_raw,
   input logic [CNT_W-1:0] rsp_current_baseline,
   input logic             rsp_calibrating
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_echo_raw)
         && $stable(rsp_current_baseline) && $stable(rsp_is_touched)
         && $stable(rsp_calibrating))
      else $error("result changed while stalled");

   // one sample in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while busy");

   // calibration results carry no touch and the cleared baseline
   a_cal_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_calibrating |-> !rsp_is_touched && (rsp_current_baseline == '0))
      else $error("calibration result with touch or baseline");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind capacitive_touch_detector_top ctd_checker u_ctd_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_if.valid),
   .req_ready            (req_if.ready),
   .rsp_valid            (rsp_if.valid),
   .rsp_ready            (rsp_if.ready),
   .rsp_is_touched       (rsp_if.is_touched),
   .rsp_echo_raw         (rsp_if.echo_raw),
   .rsp_current_baseline (rsp_if.current_baseline),
   .rsp_calibrating      (rsp_if.calibrating)
);
